// File: hdl/tmb_pkg.sv
// Package for the model matrix builder: widths, CORDIC constants, arctangent table.
// Used by tmb_sincos, trs_model_matrix_build and its checker.
`timescale 1ns / 1ps
package tmb_pkg;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int TRIG_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int TW = 34;
  localparam int FRAC_TRIG = 30;
  localparam logic signed [TW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef logic signed [TW-1:0] trig_t;

  function automatic trig_t atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
      3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
      15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return trig_t'({2'b00, v});
  endfunction
endpackage

// File: hdl/tmb_sincos.sv
// Pipelined CORDIC sine and cosine, one rotation per stage, quadrant fixed at the end.
// Depends on tmb_pkg.
`timescale 1ns / 1ps
module tmb_sincos import tmb_pkg::*; #(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int TRIG_STEPS  = TRIG_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output trig_t                  cos_o,
  output trig_t                  sin_o
);
  localparam int N = (TRIG_STEPS < ATAN_ENTRIES) ? TRIG_STEPS : ATAN_ENTRIES;
  trig_t x_r [N+1];
  trig_t y_r [N+1];
  trig_t z_r [N+1];
  logic [1:0] q_r [N+1];
  logic [31:0] a32;

  assign a32 = {angle, {(32-ANGLE_WIDTH){1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= trig_t'({4'b0, a32[29:0]});
      q_r[0] <= a32[31:30];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][TW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_turn(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_turn(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[N])
        2'd0: begin cos_o <= x_r[N];  sin_o <= y_r[N];  end
        2'd1: begin cos_o <= -y_r[N]; sin_o <= x_r[N];  end
        2'd2: begin cos_o <= -x_r[N]; sin_o <= -y_r[N]; end
        default: begin cos_o <= y_r[N]; sin_o <= -x_r[N]; end
      endcase
    end
  end
endmodule

// File: hdl/trs_model_matrix_build.sv
// Model matrix builder top level: CORDIC trig, rotation products, scaling, saturation.
// Depends on tmb_pkg and tmb_sincos.
//
//   channel | direction | fields
//   in_     | input     | pos, angle, scl per axis
//   out_    | output    | m_r0_c0 .. m_r2_c2, move_x/y/z
//
// One transfer per cycle while the output is not stalled. A result passes through the CORDIC
// load, rotation and quadrant stages, six product and scaling stages and the output register
// before out_valid. rst_n clears only the valid bits. The whole pipeline holds when
// the output stage is full and out_ready is low; nothing is dropped or repeated.
`timescale 1ns / 1ps
module trs_model_matrix_build import tmb_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int TRIG_STEPS  = TRIG_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_pos_x,
  input  logic signed [VALUE_WIDTH-1:0] in_pos_y,
  input  logic signed [VALUE_WIDTH-1:0] in_pos_z,
  input  logic [ANGLE_WIDTH-1:0] in_angle_x,
  input  logic [ANGLE_WIDTH-1:0] in_angle_y,
  input  logic [ANGLE_WIDTH-1:0] in_angle_z,
  input  logic signed [VALUE_WIDTH-1:0] in_scl_x,
  input  logic signed [VALUE_WIDTH-1:0] in_scl_y,
  input  logic signed [VALUE_WIDTH-1:0] in_scl_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_m_r0_c0,
  output logic signed [VALUE_WIDTH-1:0] out_m_r0_c1,
  output logic signed [VALUE_WIDTH-1:0] out_m_r0_c2,
  output logic signed [VALUE_WIDTH-1:0] out_m_r1_c0,
  output logic signed [VALUE_WIDTH-1:0] out_m_r1_c1,
  output logic signed [VALUE_WIDTH-1:0] out_m_r1_c2,
  output logic signed [VALUE_WIDTH-1:0] out_m_r2_c0,
  output logic signed [VALUE_WIDTH-1:0] out_m_r2_c1,
  output logic signed [VALUE_WIDTH-1:0] out_m_r2_c2,
  output logic signed [VALUE_WIDTH-1:0] out_move_x,
  output logic signed [VALUE_WIDTH-1:0] out_move_y,
  output logic signed [VALUE_WIDTH-1:0] out_move_z
);
  localparam int N = (TRIG_STEPS < ATAN_ENTRIES) ? TRIG_STEPS : ATAN_ENTRIES;
  localparam int TLAT = N + 2;
  localparam int LAT = TLAT + 6;
  localparam int VW = VALUE_WIDTH;
  localparam int PW = 2 * TW;
  localparam int HW = VW - 16 + 1;
  localparam int EW = TW + HW + 1;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [EW-1:0] ent_t;

  logic en;
  logic [LAT-1:0] vld_r;
  logic out_vld_r;

  assign en = !out_vld_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
      out_vld_r <= vld_r[LAT-1];
    end
  end
  assign out_valid = out_vld_r;

  // delay line for positions and scales
  val_t px_r [LAT], py_r [LAT], pz_r [LAT];
  val_t sx_r [LAT], sy_r [LAT], sz_r [LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0] <= in_pos_x; py_r[0] <= in_pos_y; pz_r[0] <= in_pos_z;
      sx_r[0] <= in_scl_x; sy_r[0] <= in_scl_y; sz_r[0] <= in_scl_z;
      for (int k = 0; k < LAT - 1; k++) begin
        px_r[k+1] <= px_r[k]; py_r[k+1] <= py_r[k]; pz_r[k+1] <= pz_r[k];
        sx_r[k+1] <= sx_r[k]; sy_r[k+1] <= sy_r[k]; sz_r[k+1] <= sz_r[k];
      end
    end
  end

  trig_t cx, snx, cy, sny, cz, snz;
  tmb_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STEPS(TRIG_STEPS)) u_tx (
    .clk(clk), .en(en), .angle(in_angle_x), .cos_o(cx), .sin_o(snx));
  tmb_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STEPS(TRIG_STEPS)) u_ty (
    .clk(clk), .en(en), .angle(in_angle_y), .cos_o(cy), .sin_o(sny));
  tmb_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STEPS(TRIG_STEPS)) u_tz (
    .clk(clk), .en(en), .angle(in_angle_z), .cos_o(cz), .sin_o(snz));

  // stage A: p = sx*sy, q = cx*sy, hold the rest
  prod_t pp_a_r, qq_a_r;
  trig_t cx_a_r, sx_a_r, cy_a_r, sy_a_r, cz_a_r, sz_a_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pp_a_r <= prod_t'(snx) * prod_t'(sny);
      qq_a_r <= prod_t'(cx) * prod_t'(sny);
      cx_a_r <= cx; sx_a_r <= snx; cy_a_r <= cy;
      sy_a_r <= sny; cz_a_r <= cz; sz_a_r <= snz;
    end
  end
  trig_t p_w, q_w;
  assign p_w = trig_t'(pp_a_r >>> FRAC_TRIG);
  assign q_w = trig_t'(qq_a_r >>> FRAC_TRIG);

  // stage B: all products, including p and q times cz and sz
  prod_t m_b_r [12];
  trig_t sy_b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      m_b_r[0]  <= prod_t'(cy_a_r) * prod_t'(cz_a_r);
      m_b_r[1]  <= prod_t'(cy_a_r) * prod_t'(sz_a_r);
      m_b_r[2]  <= prod_t'(cx_a_r) * prod_t'(sz_a_r);
      m_b_r[3]  <= prod_t'(p_w) * prod_t'(cz_a_r);
      m_b_r[4]  <= prod_t'(cx_a_r) * prod_t'(cz_a_r);
      m_b_r[5]  <= prod_t'(p_w) * prod_t'(sz_a_r);
      m_b_r[6]  <= prod_t'(sx_a_r) * prod_t'(cy_a_r);
      m_b_r[7]  <= prod_t'(sx_a_r) * prod_t'(sz_a_r);
      m_b_r[8]  <= prod_t'(q_w) * prod_t'(cz_a_r);
      m_b_r[9]  <= prod_t'(sx_a_r) * prod_t'(cz_a_r);
      m_b_r[10] <= prod_t'(q_w) * prod_t'(sz_a_r);
      m_b_r[11] <= prod_t'(cx_a_r) * prod_t'(cy_a_r);
      sy_b_r <= sy_a_r;
    end
  end

  // stage C: combine to rotation entries
  trig_t r_c_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      r_c_r[0] <= trig_t'(m_b_r[0] >>> FRAC_TRIG);
      r_c_r[1] <= trig_t'((-m_b_r[1]) >>> FRAC_TRIG);
      r_c_r[2] <= sy_b_r;
      r_c_r[3] <= trig_t'((m_b_r[2] + m_b_r[3]) >>> FRAC_TRIG);
      r_c_r[4] <= trig_t'((m_b_r[4] - m_b_r[5]) >>> FRAC_TRIG);
      r_c_r[5] <= trig_t'((-m_b_r[6]) >>> FRAC_TRIG);
      r_c_r[6] <= trig_t'((m_b_r[7] - m_b_r[8]) >>> FRAC_TRIG);
      r_c_r[7] <= trig_t'((m_b_r[9] + m_b_r[10]) >>> FRAC_TRIG);
      r_c_r[8] <= trig_t'(m_b_r[11] >>> FRAC_TRIG);
    end
  end

  // stage D: split scale products; stage E: add and shift; stage F: saturate
  val_t scl_d [9];
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      case (k % 3)
        0: scl_d[k] = sx_r[TLAT + 2];
        1: scl_d[k] = sy_r[TLAT + 2];
        default: scl_d[k] = sz_r[TLAT + 2];
      endcase
    end
  end

  ent_t hi_d_r [9], lo_d_r [9];
  ent_t v_e_r [9];
  val_t o_r [9];
  localparam ent_t MAXV = ent_t'({1'b0, {(VW-1){1'b1}}});
  localparam ent_t MINV = -MAXV - ent_t'(1);
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        hi_d_r[k] <= ent_t'(r_c_r[k]) * ent_t'(scl_d[k] >>> 16);
        lo_d_r[k] <= ent_t'(r_c_r[k]) * ent_t'({1'b0, scl_d[k][15:0]});
        v_e_r[k] <= (hi_d_r[k] + (lo_d_r[k] >>> 16)) >>> 14;
        if (v_e_r[k] > MAXV) o_r[k] <= val_t'(MAXV);
        else if (v_e_r[k] < MINV) o_r[k] <= val_t'(MINV);
        else o_r[k] <= val_t'(v_e_r[k]);
      end
    end
  end

  // output register
  val_t mo_r [9];
  val_t mvx_r, mvy_r, mvz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) mo_r[k] <= o_r[k];
      mvx_r <= px_r[LAT - 1]; mvy_r <= py_r[LAT - 1]; mvz_r <= pz_r[LAT - 1];
    end
  end

  assign out_m_r0_c0 = mo_r[0];
  assign out_m_r0_c1 = mo_r[1];
  assign out_m_r0_c2 = mo_r[2];
  assign out_m_r1_c0 = mo_r[3];
  assign out_m_r1_c1 = mo_r[4];
  assign out_m_r1_c2 = mo_r[5];
  assign out_m_r2_c0 = mo_r[6];
  assign out_m_r2_c1 = mo_r[7];
  assign out_m_r2_c2 = mo_r[8];
  assign out_move_x = mvx_r;
  assign out_move_y = mvy_r;
  assign out_move_z = mvz_r;
endmodule

// File: hdl/tmb_checker.sv
// Port-level checks for trs_model_matrix_build, attached by bind.
// Depends on tmb_pkg.
`timescale 1ns / 1ps
module tmb_checker import tmb_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [VALUE_WIDTH_DEF-1:0] out_move_x
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_move_x))
    else $error("result dropped or changed under stall");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind trs_model_matrix_build tmb_checker u_tmb_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_move_x(out_move_x));
